[rtl/sbl_pkg.sv]
// ----------------------------------------------------------------------------
// sbl_pkg
// shared widths, action and status codes, and the control word that the
// sorted byte list broadcasts to its row of cells
// ----------------------------------------------------------------------------
package sbl_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // broadcast control for every cell
  typedef struct packed {
    logic               ins;    // insert value, shift upper part up
    logic               del;    // remove first match, shift upper part down
    logic               rot;    // rotate valid entries by one toward cell 0
    logic [VALUE_W-1:0] value;  // operand of insert and delete
  } cell_ctl_t;

endpackage

[rtl/sbl_if.sv]
// ----------------------------------------------------------------------------
// sbl_if
// valid/ready channels of the sorted byte list: request beats in, result
// beats out
// ----------------------------------------------------------------------------
interface sbl_in_if import sbl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sbl_out_if import sbl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  item;
  logic [COUNT_W-1:0]  count;
  logic                last;

  modport source (output valid, output status, output item, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input item, input count,
                  input last, output ready);
endinterface

[rtl/sbl_cell.sv]
// ----------------------------------------------------------------------------
// sbl_cell
// one slot of the sorted list: holds an entry and its valid bit, compares
// against the broadcast operand and takes data from a neighbor on a shift
// ----------------------------------------------------------------------------
module sbl_cell import sbl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [VALUE_W-1:0] head_entry,
  input  logic [VALUE_W-1:0] left_entry,
  input  logic               left_valid,
  input  logic               left_ge,
  input  logic               left_hit,
  input  logic [VALUE_W-1:0] right_entry,
  input  logic               right_valid,
  output logic [VALUE_W-1:0] entry,
  output logic               valid,
  output logic               ge,
  output logic               hit
);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               valid_r;
  logic               valid_nxt;

  always_comb begin
    // empty slots count as "greater or equal" so the insert point is found
    ge  = !valid_r || (entry_r >= ctl.value);
    // running flag: a match sits here or further left
    hit = left_hit || (valid_r && (entry_r == ctl.value));

    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (ge) begin
        if (left_ge) begin
          entry_nxt = left_entry;
          valid_nxt = left_valid;
        end else begin
          entry_nxt = ctl.value;
          valid_nxt = 1'b1;
        end
      end
    end else if (ctl.del) begin
      if (hit) begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
    end else if (ctl.rot && valid_r) begin
      // last occupied slot wraps around to the head
      entry_nxt = right_valid ? right_entry : head_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

[rtl/sorted_byte_list.sv]
// ----------------------------------------------------------------------------
// sorted_byte_list
// ascending list of up to CAPACITY unsigned bytes, duplicates allowed, kept
// in a row of cells; insert, delete of first match, and in-order readout
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents              accepted when
//  --------  ---  -------------------------  ---------------------------
//  in_ch     in   action, value              in_ch.valid && in_ch.ready
//  out_ch    out  status, item, count, last  out_ch.valid && out_ch.ready
//
//  insert and delete: every cell compares against the value at once and the
//  row shifts by one slot as the request is taken
//  readout sends one result beat per entry: the row rotates toward cell 0
//  once per result beat, so the list is back in place after the last beat
//  a new request is taken only while idle and the output register is free
//  or being emptied; an output stall freezes the readout rotation
//  reset (synchronous, active low) clears the fill count and cell valid bits
//
module sorted_byte_list import sbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sbl_in_if.sink    in_ch,
  sbl_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] fill_r, fill_nxt;       // entries held
  logic [CNT_W-1:0] rd_left_r, rd_left_nxt; // readout beats still to send

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_item_r, out_item_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  // cell row
  logic [VALUE_W-1:0] cell_entry [CAPACITY];
  logic               cell_valid [CAPACITY];
  logic               cell_ge    [CAPACITY];
  logic               cell_hit   [CAPACITY];
  cell_ctl_t          ctl;

  logic out_free;
  logic in_ready;
  logic in_fire;
  logic full;
  logic empty;
  logic found;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ready;
  assign full     = (fill_r == CNT_W'(CAPACITY));
  assign empty    = (fill_r == '0);
  // running match flag reaches the far end only if some entry matched
  assign found    = cell_hit[CAPACITY-1];

  // broadcast control: the list only changes on a successful operation
  always_comb begin
    ctl.value = in_ch.value;
    ctl.ins   = in_fire && (in_ch.action == ACT_INSERT) && !full;
    ctl.del   = in_fire && (in_ch.action == ACT_DELETE) && !empty && found;
    ctl.rot   = (state_r == S_READ) && out_free;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] left_entry;
    logic               left_valid;
    logic               left_ge;
    logic               left_hit;
    logic [VALUE_W-1:0] right_entry;
    logic               right_valid;

    if (g == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_ge    = 1'b0;
      assign left_hit   = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[g-1];
      assign left_valid = cell_valid[g-1];
      assign left_ge    = cell_ge[g-1];
      assign left_hit   = cell_hit[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = cell_entry[g+1];
      assign right_valid = cell_valid[g+1];
    end

    sbl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .head_entry  (cell_entry[0]),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .left_ge     (left_ge),
      .left_hit    (left_hit),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (cell_entry[g]),
      .valid       (cell_valid[g]),
      .ge          (cell_ge[g]),
      .hit         (cell_hit[g])
    );
  end

  // next state, fill count and result beat
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rd_left_nxt    = rd_left_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (in_fire) begin
      case (in_ch.action)
        ACT_INSERT: begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = in_ch.value;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_status_nxt = ST_FULL;
            out_count_nxt  = COUNT_W'(fill_r);
          end else begin
            fill_nxt       = CNT_W'(fill_r + 1'b1);
            out_status_nxt = ST_OK;
            out_count_nxt  = COUNT_W'(fill_r + 1'b1);
          end
        end
        ACT_DELETE: begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = in_ch.value;
          out_last_nxt  = 1'b1;
          if (empty) begin
            out_status_nxt = ST_EMPTY;
            out_count_nxt  = '0;
          end else if (!found) begin
            out_status_nxt = ST_NOT_FOUND;
            out_count_nxt  = COUNT_W'(fill_r);
          end else begin
            fill_nxt       = CNT_W'(fill_r - 1'b1);
            out_status_nxt = ST_OK;
            out_count_nxt  = COUNT_W'(fill_r - 1'b1);
          end
        end
        ACT_READ: begin
          if (empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_item_nxt   = '0;
            out_count_nxt  = '0;
            out_last_nxt   = 1'b1;
          end else begin
            state_nxt   = S_READ;
            rd_left_nxt = fill_r;
          end
        end
        default: begin
          // unused action code: no beat, no change
        end
      endcase
    end

    // readout: send the head cell, the row rotates underneath
    if (ctl.rot) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_item_nxt   = cell_entry[0];
      out_count_nxt  = COUNT_W'(fill_r);
      out_last_nxt   = (rd_left_r == CNT_W'(1));
      rd_left_nxt    = CNT_W'(rd_left_r - 1'b1);
      if (rd_left_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_left_r   <= rd_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.item   = out_item_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.last   = out_last_r;

endmodule

[rtl/sbl_checker.sv]
// ----------------------------------------------------------------------------
// sbl_checker
// port-level checks on the sorted byte list, bound to the top level
// ----------------------------------------------------------------------------
module sbl_checker import sbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [VALUE_W-1:0]  out_item,
  input logic [COUNT_W-1:0]  out_count,
  input logic                out_last
);

  // a request is never taken while a result beat is stuck
  a_ready_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("request taken while result beat stalled");

  // every error result ends its request
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error result not marked last");

  // dropped insert only happens with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == COUNT_W'(CAPACITY)))
    else $error("full status with wrong count");

  // empty status reports no entries held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
      && $stable(out_item) && $stable(out_count) && $stable(out_last)))
    else $error("result beat changed under stall");

endmodule

bind sorted_byte_list sbl_checker #(.CAPACITY(CAPACITY)) u_sbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_item   (out_ch.item),
  .out_count  (out_ch.count),
  .out_last   (out_ch.last)
);
